[rtl/cell_face_transmissibility_defines.svh]
// Assertion macros for the cell face transmissibility block.
// Included by the top level; no other dependencies.
`ifndef CELL_FACE_TRANSMISSIBILITY_DEFINES_SVH
`define CELL_FACE_TRANSMISSIBILITY_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CFT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define CFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cft_pkg.sv]
// Package for the cell face transmissibility block: constants, codes,
// divider lane type and the one-bit restoring division step. No dependencies.
`default_nettype none

package cft_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DIV_STEPS = 64;
  localparam logic [31:0] DARCY_RESET = 32'd559;
  localparam logic [47:0] OUT_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [16:0] DIP_ONE = 17'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    DIR_X = 2'd0,
    DIR_Y = 2'd1,
    DIR_Z = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_DIV  = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  // rem < dsr holds while the quotient fits; word shifts dividend out, quotient in
  typedef struct packed {
    logic [48:0] rem;
    logic [63:0] word;
    logic [48:0] dsr;
  } div_lane_t;

  function automatic div_lane_t div_step(div_lane_t l);
    div_lane_t   r;
    logic [49:0] t;
    logic [50:0] dif;
    t      = {l.rem, l.word[63]};
    dif    = {1'b0, t} - {2'b0, l.dsr};
    r      = l;
    r.rem  = dif[50] ? t[48:0] : dif[48:0];
    r.word = {l.word[62:0], ~dif[50]};
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/cell_face_transmissibility.sv]
// Two-point face transmissibility between two Cartesian grid cells, fully pipelined.
// Depends on cft_pkg and cell_face_transmissibility_defines.svh.
//
// Usage:
//   Input stream: one cell pair per transfer; tuser carries the axis, tdata the
//   extents, permeabilities, depths and multiplier. Output stream: one result per
//   pair; tdata is the Q32.16 transmissibility, tuser the status (ok, zero
//   divisor, saturated). The cfg channel writes the Darcy factor (Q16.16); it is
//   always ready and must only be written while no pair is in flight.
//   Throughput: one pair per cycle while the output is not stalled. Two 64-stage
//   restoring dividers run in series (area, half-sum of length over permeability
//   and dip factor in parallel, then the final divide by the mean), with split
//   multiplier and adder stages around them.
//   Reset: pipeline and output empty, Darcy factor back to 559.
//   Backpressure: the output register holds its result while tready is low; the
//   pipeline keeps moving and taking input until a valid result reaches its last
//   stage, then the whole pipeline and s_axis_tready hold until the output drains.
`default_nettype none

module cell_face_transmissibility (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // size_x_a, size_y_a, size_z_a, size_x_b, size_y_b, size_z_b, perm_a, perm_b,
  // depth_a, depth_b, multiplier (32 bits each, from bit 0 up)
  input  logic [351:0] s_axis_tdata,
  // direction
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // transmissibility
  output logic [47:0]  m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);

  import cft_pkg::*;

`include "cell_face_transmissibility_defines.svh"

  typedef struct packed {
    logic [31:0] la, lb, a1, a2, b1, b2;
    logic [32:0] sum;
    logic [31:0] mag, pa, pb, mult;
    logic        zero, dip;
  } s1_t;

  typedef struct packed {
    logic [31:0] la, lb;
    logic [63:0] wa_p, wb_p, dhs_p, dvs_p;
    logic [32:0] sum;
    logic [31:0] pa, pb, mult;
    logic        zero, dip;
  } s2_t;

  typedef struct packed {
    logic [63:0] pla, plb;
    logic [47:0] pha, phb;
    logic [48:0] dd;
    logic [47:0] dhs;
    logic [31:0] la, lb;
    logic [32:0] sum;
    logic [31:0] pa, pb, mult;
    logic        zero, dipone;
  } s3_t;

  typedef struct packed {
    logic [63:0] mqa, mqb;
    logic [48:0] dd;
    logic [47:0] dhs;
    logic [31:0] la, lb;
    logic [32:0] sum;
    logic [31:0] pa, pb, mult;
    logic        zero, dipone;
  } s4_t;

  typedef struct packed {
    logic [63:0] n;
    logic        over;
    logic [48:0] dd;
    logic [47:0] dhs;
    logic [31:0] la, lb;
    logic [32:0] sum;
    logic [31:0] pa, pb, mult;
    logic        zero, dipone;
  } s5_t;

  typedef struct packed {
    logic        zero, over, dipone;
    logic [31:0] mult;
  } side_a_t;

  typedef struct packed {
    div_lane_t [3:0] lane;
    side_a_t         side;
  } da_t;

  typedef struct packed {
    logic [63:0] m0, m1;
    logic [47:0] b;
    logic [16:0] dipc;
    logic        zero, over;
    logic [31:0] mult;
  } p1_t;

  typedef struct packed {
    logic [63:0] y1;
    logic [47:0] b;
    logic [16:0] dipc;
    logic        zero, over;
    logic [31:0] mult;
  } p2_t;

  typedef struct packed {
    logic [48:0] n0, n1;
    logic [47:0] b;
    logic        zero, over;
    logic [31:0] mult;
  } p3_t;

  typedef struct packed {
    logic [63:0] y;
    logic [47:0] b;
    logic        zero, over;
    logic [31:0] mult;
  } p4_t;

  typedef struct packed {
    logic        zero, over;
    logic [31:0] mult;
  } side_b_t;

  typedef struct packed {
    div_lane_t lane;
    side_b_t   side;
  } db_t;

  typedef struct packed {
    logic [63:0] t0, t1;
    logic        zero, over;
  } q1_t;

  typedef struct packed {
    logic [63:0] res;
    logic        zero, over;
  } q2_t;

  logic        en;
  logic [31:0] darcy_q;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  da_t da_d [DIV_STEPS+1];
  da_t da_q [DIV_STEPS+1];
  p1_t p1_d, p1_q;
  p2_t p2_d, p2_q;
  p3_t p3_d, p3_q;
  p4_t p4_d, p4_q;
  db_t db_d [DIV_STEPS+1];
  db_t db_q [DIV_STEPS+1];
  q1_t q1_d, q1_q;
  q2_t q2_d, q2_q;

  logic [4:0]         vs_q;
  logic [DIV_STEPS:0] vda_q;
  logic [3:0]         vp_q;
  logic [DIV_STEPS:0] vdb_q;
  logic [1:0]         vq_q;

  logic        out_valid_q;
  logic [47:0] out_data_d, out_data_q;
  status_e     out_status_d, out_status_q;

  // Config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      darcy_q <= DARCY_RESET;
    end else if (cfg_valid_i) begin
      darcy_q <= cfg_data_i;
    end
  end

  // Hold only when a result is ready to leave and the output slot is blocked
  assign en            = !(vq_q[1] && out_valid_q && !m_axis_tready);
  assign s_axis_tready = en;

  // Stage 1: axis select, length sum, depth difference
  always_comb begin
    logic [31:0] xa, ya, za, xb, yb, zb;
    logic [32:0] dv, dvn;
    xa = s_axis_tdata[31:0];
    ya = s_axis_tdata[63:32];
    za = s_axis_tdata[95:64];
    xb = s_axis_tdata[127:96];
    yb = s_axis_tdata[159:128];
    zb = s_axis_tdata[191:160];
    s1_d.pa   = s_axis_tdata[223:192];
    s1_d.pb   = s_axis_tdata[255:224];
    s1_d.mult = s_axis_tdata[351:320];
    case (s_axis_tuser)
      DIR_X: begin
        s1_d.la = xa; s1_d.lb = xb;
        s1_d.a1 = ya; s1_d.a2 = za; s1_d.b1 = yb; s1_d.b2 = zb;
      end
      DIR_Y: begin
        s1_d.la = ya; s1_d.lb = yb;
        s1_d.a1 = xa; s1_d.a2 = za; s1_d.b1 = xb; s1_d.b2 = zb;
      end
      default: begin
        s1_d.la = za; s1_d.lb = zb;
        s1_d.a1 = xa; s1_d.a2 = ya; s1_d.b1 = xb; s1_d.b2 = yb;
      end
    endcase
    s1_d.dip  = (s_axis_tuser == DIR_X) || (s_axis_tuser == DIR_Y);
    s1_d.sum  = {1'b0, s1_d.la} + {1'b0, s1_d.lb};
    s1_d.zero = (s1_d.sum == '0) || (s1_d.pa == '0) || (s1_d.pb == '0);
    dv  = {s_axis_tdata[287], s_axis_tdata[287:256]} - {s_axis_tdata[319], s_axis_tdata[319:288]};
    dvn = 33'd0 - dv;
    s1_d.mag = dv[32] ? dvn[31:0] : dv[31:0];
  end

  // Stage 2: cross sections and squares
  always_comb begin
    logic [31:0] h;
    h          = s1_q.sum[32:1];
    s2_d.la    = s1_q.la;
    s2_d.lb    = s1_q.lb;
    s2_d.wa_p  = 64'(s1_q.a1) * 64'(s1_q.a2);
    s2_d.wb_p  = 64'(s1_q.b1) * 64'(s1_q.b2);
    s2_d.dhs_p = 64'(h) * 64'(h);
    s2_d.dvs_p = 64'(s1_q.mag) * 64'(s1_q.mag);
    s2_d.sum   = s1_q.sum;
    s2_d.pa    = s1_q.pa;
    s2_d.pb    = s1_q.pb;
    s2_d.mult  = s1_q.mult;
    s2_d.zero  = s1_q.zero;
    s2_d.dip   = s1_q.dip;
  end

  // Stage 3: partial products of length times cross section, dip divisor
  always_comb begin
    logic [47:0] wa, wb, dvs;
    wa          = s2_q.wa_p[63:FRAC_BITS];
    wb          = s2_q.wb_p[63:FRAC_BITS];
    dvs         = s2_q.dvs_p[63:FRAC_BITS];
    s3_d.dhs    = s2_q.dhs_p[63:FRAC_BITS];
    s3_d.pla    = 64'(s2_q.lb) * 64'(wa[31:0]);
    s3_d.pha    = 48'(s2_q.lb) * 48'(wa[47:32]);
    s3_d.plb    = 64'(s2_q.la) * 64'(wb[31:0]);
    s3_d.phb    = 48'(s2_q.la) * 48'(wb[47:32]);
    s3_d.dd     = 49'(s3_d.dhs) + 49'(dvs);
    s3_d.dipone = !s2_q.dip || (dvs == '0);
    s3_d.la     = s2_q.la;
    s3_d.lb     = s2_q.lb;
    s3_d.sum    = s2_q.sum;
    s3_d.pa     = s2_q.pa;
    s3_d.pb     = s2_q.pb;
    s3_d.mult   = s2_q.mult;
    s3_d.zero   = s2_q.zero;
  end

  // Stage 4: combine partial products
  always_comb begin
    logic [79:0] pra, prb;
    pra         = 80'(s3_q.pla) + {s3_q.pha, 32'b0};
    prb         = 80'(s3_q.plb) + {s3_q.phb, 32'b0};
    s4_d.mqa    = pra[79:16];
    s4_d.mqb    = prb[79:16];
    s4_d.dd     = s3_q.dd;
    s4_d.dhs    = s3_q.dhs;
    s4_d.la     = s3_q.la;
    s4_d.lb     = s3_q.lb;
    s4_d.sum    = s3_q.sum;
    s4_d.pa     = s3_q.pa;
    s4_d.pb     = s3_q.pb;
    s4_d.mult   = s3_q.mult;
    s4_d.zero   = s3_q.zero;
    s4_d.dipone = s3_q.dipone;
  end

  // Stage 5: area numerator
  always_comb begin
    logic [64:0] t;
    t           = 65'(s4_q.mqa) + 65'(s4_q.mqb);
    s5_d.n      = t[63:0];
    s5_d.over   = t[64];
    s5_d.dd     = s4_q.dd;
    s5_d.dhs    = s4_q.dhs;
    s5_d.la     = s4_q.la;
    s5_d.lb     = s4_q.lb;
    s5_d.sum    = s4_q.sum;
    s5_d.pa     = s4_q.pa;
    s5_d.pb     = s4_q.pb;
    s5_d.mult   = s4_q.mult;
    s5_d.zero   = s4_q.zero;
    s5_d.dipone = s4_q.dipone;
  end

  // Divider bank A: area, two length/permeability quotients, dip factor
  always_comb begin
    da_d[0].lane[0].rem  = 49'(s5_q.n[63:48]);
    da_d[0].lane[0].word = {s5_q.n[47:0], 16'b0};
    da_d[0].lane[0].dsr  = 49'(s5_q.sum);
    da_d[0].lane[1].rem  = '0;
    da_d[0].lane[1].word = {16'b0, s5_q.la, 16'b0};
    da_d[0].lane[1].dsr  = 49'(s5_q.pa);
    da_d[0].lane[2].rem  = '0;
    da_d[0].lane[2].word = {16'b0, s5_q.lb, 16'b0};
    da_d[0].lane[2].dsr  = 49'(s5_q.pb);
    da_d[0].lane[3].rem  = '0;
    da_d[0].lane[3].word = {s5_q.dhs, 16'b0};
    da_d[0].lane[3].dsr  = s5_q.dd;
    da_d[0].side.zero    = s5_q.zero;
    da_d[0].side.over    = s5_q.over || (33'(s5_q.n[63:48]) >= s5_q.sum);
    da_d[0].side.dipone  = s5_q.dipone;
    da_d[0].side.mult    = s5_q.mult;
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int j = 0; j < 4; j++) begin
        da_d[k+1].lane[j] = div_step(da_q[k].lane[j]);
      end
      da_d[k+1].side = da_q[k].side;
    end
  end

  // P1: half sum of quotients, dip factor select, Darcy partial products
  always_comb begin
    logic [48:0] bsum;
    logic [63:0] area;
    bsum      = 49'(da_q[DIV_STEPS].lane[1].word[47:0]) +
                49'(da_q[DIV_STEPS].lane[2].word[47:0]);
    area      = da_q[DIV_STEPS].lane[0].word;
    p1_d.b    = bsum[48:1];
    p1_d.zero = da_q[DIV_STEPS].side.zero || (p1_d.b == '0);
    p1_d.over = da_q[DIV_STEPS].side.over;
    p1_d.dipc = da_q[DIV_STEPS].side.dipone ? DIP_ONE : da_q[DIV_STEPS].lane[3].word[16:0];
    p1_d.m0   = 64'(darcy_q) * 64'(area[31:0]);
    p1_d.m1   = 64'(darcy_q) * 64'(area[63:32]);
    p1_d.mult = da_q[DIV_STEPS].side.mult;
  end

  always_comb begin
    logic [95:0] pr;
    pr        = 96'(p1_q.m0) + {p1_q.m1, 32'b0};
    p2_d.y1   = pr[79:16];
    p2_d.over = p1_q.over || (pr[95:80] != '0);
    p2_d.b    = p1_q.b;
    p2_d.dipc = p1_q.dipc;
    p2_d.zero = p1_q.zero;
    p2_d.mult = p1_q.mult;
  end

  always_comb begin
    p3_d.n0   = 49'(p2_q.y1[31:0]) * 49'(p2_q.dipc);
    p3_d.n1   = 49'(p2_q.y1[63:32]) * 49'(p2_q.dipc);
    p3_d.b    = p2_q.b;
    p3_d.zero = p2_q.zero;
    p3_d.over = p2_q.over;
    p3_d.mult = p2_q.mult;
  end

  always_comb begin
    logic [80:0] pr;
    pr        = 81'(p3_q.n0) + {p3_q.n1, 32'b0};
    p4_d.y    = pr[79:16];
    p4_d.over = p3_q.over || pr[80];
    p4_d.b    = p3_q.b;
    p4_d.zero = p3_q.zero;
    p4_d.mult = p3_q.mult;
  end

  // Divider B: divide by the mean of length over permeability
  always_comb begin
    db_d[0].lane.rem  = 49'(p4_q.y[63:48]);
    db_d[0].lane.word = {p4_q.y[47:0], 16'b0};
    db_d[0].lane.dsr  = {1'b0, p4_q.b};
    db_d[0].side.zero = p4_q.zero;
    db_d[0].side.over = p4_q.over || (48'(p4_q.y[63:48]) >= p4_q.b);
    db_d[0].side.mult = p4_q.mult;
    for (int k = 0; k < DIV_STEPS; k++) begin
      db_d[k+1].lane = div_step(db_q[k].lane);
      db_d[k+1].side = db_q[k].side;
    end
  end

  // Q1/Q2: multiplier
  always_comb begin
    logic [63:0] t;
    t         = db_q[DIV_STEPS].lane.word;
    q1_d.t0   = 64'(t[31:0]) * 64'(db_q[DIV_STEPS].side.mult);
    q1_d.t1   = 64'(t[63:32]) * 64'(db_q[DIV_STEPS].side.mult);
    q1_d.zero = db_q[DIV_STEPS].side.zero;
    q1_d.over = db_q[DIV_STEPS].side.over;
  end

  always_comb begin
    logic [95:0] pr;
    pr        = 96'(q1_q.t0) + {q1_q.t1, 32'b0};
    q2_d.res  = pr[79:16];
    q2_d.over = q1_q.over || (pr[95:80] != '0);
    q2_d.zero = q1_q.zero;
  end

  // Final status
  always_comb begin
    if (q2_q.zero) begin
      out_data_d   = '0;
      out_status_d = ST_ZERO_DIV;
    end else if (q2_q.over || (q2_q.res[63:48] != '0)) begin
      out_data_d   = OUT_MAX;
      out_status_d = ST_SATURATED;
    end else begin
      out_data_d   = q2_q.res[47:0];
      out_status_d = ST_OK;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        da_q[k] <= da_d[k];
        db_q[k] <= db_d[k];
      end
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      p4_q <= p4_d;
      q1_q <= q1_d;
      q2_q <= q2_d;
    end
    if (en && vq_q[1]) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q  <= '0;
      vda_q <= '0;
      vp_q  <= '0;
      vdb_q <= '0;
      vq_q  <= '0;
    end else if (en) begin
      vs_q  <= {vs_q[3:0], s_axis_tvalid};
      vda_q <= {vda_q[DIV_STEPS-1:0], vs_q[4]};
      vp_q  <= {vp_q[2:0], vda_q[DIV_STEPS]};
      vdb_q <= {vdb_q[DIV_STEPS-1:0], vp_q[3]};
      vq_q  <= {vq_q[0], vdb_q[DIV_STEPS]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && vq_q[1]) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

  `CFT_ASSERT_IMPL(a_zero_div_clears, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == ST_ZERO_DIV), m_axis_tdata == '0, "zero divisor result not cleared")
  `CFT_ASSERT_IMPL(a_sat_is_max, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == ST_SATURATED), m_axis_tdata == OUT_MAX, "saturated result not at maximum")
  `CFT_ASSERT_NEXT(a_last_stage_drains, clk_i, rst_ni, vq_q[1] && s_axis_tready, m_axis_tvalid, "result lost at output register")

endmodule

`default_nettype wire

[sim/cell_face_transmissibility_test.sv]
// Testbench for cell_face_transmissibility: directed, random and backpressure pairs,
// checked against a fixed-point transmissibility predictor. Depends on cft_pkg.
`default_nettype none

module cell_face_transmissibility_test;
  import cft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // lowest field last so that it lands in the low bits of tdata
  typedef struct packed {
    logic [31:0]        mult;
    logic signed [31:0] depth_b;
    logic signed [31:0] depth_a;
    logic [31:0]        perm_b;
    logic [31:0]        perm_a;
    logic [31:0]        size_z_b;
    logic [31:0]        size_y_b;
    logic [31:0]        size_x_b;
    logic [31:0]        size_z_a;
    logic [31:0]        size_y_a;
    logic [31:0]        size_x_a;
  } pair_t;

  typedef struct {
    logic [47:0] trans;
    logic [1:0]  st;
  } face_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [351:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  cell_face_transmissibility uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #2 clk_i = ~clk_i;

  face_result_t pending_results[$];
  logic [31:0]  darcy_q = DARCY_RESET;
  bit           ovf;
  bit           idle_en = 1'b1;
  int           long_stall = 0;
  int           errors = 0;
  int           n_sent = 0, n_ok = 0, n_zero = 0, n_sat = 0, n_cfg = 0;

  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    if (p[127:80] != 0) begin
      ovf = 1'b1;
      return '1;
    end
    return p[79:16];
  endfunction

  function automatic logic [63:0] q_div(logic [63:0] n, logic [63:0] d);
    logic [79:0] q;
    q = {n, 16'b0} / {16'b0, d};
    if (q[79:64] != 0) begin
      ovf = 1'b1;
      return '1;
    end
    return q[63:0];
  endfunction

  function automatic logic [63:0] q_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      ovf = 1'b1;
      return '1;
    end
    return s[63:0];
  endfunction

  function automatic face_result_t predict_transmissibility(logic [1:0] dir, pair_t p);
    face_result_t r;
    logic [63:0]  la, lb, wa, wb, area, mean, dip, t, h, dhs, dvs, mag;
    logic [64:0]  len_sum, half;
    logic signed [33:0] dv;
    ovf = 1'b0;
    case (dir)
      DIR_X: begin
        la = p.size_x_a; lb = p.size_x_b;
        wa = q_mul(p.size_y_a, p.size_z_a); wb = q_mul(p.size_y_b, p.size_z_b);
      end
      DIR_Y: begin
        la = p.size_y_a; lb = p.size_y_b;
        wa = q_mul(p.size_x_a, p.size_z_a); wb = q_mul(p.size_x_b, p.size_z_b);
      end
      default: begin
        la = p.size_z_a; lb = p.size_z_b;
        wa = q_mul(p.size_x_a, p.size_y_a); wb = q_mul(p.size_x_b, p.size_y_b);
      end
    endcase
    len_sum = la + lb;
    r.trans = '0;
    r.st = ST_ZERO_DIV;
    if (len_sum == 0 || p.perm_a == 0 || p.perm_b == 0) return r;
    area = q_div(q_add(q_mul(lb, wa), q_mul(la, wb)), len_sum[63:0]);
    half = {1'b0, q_div(la, p.perm_a)} + {1'b0, q_div(lb, p.perm_b)};
    mean = half[64:1];
    if (mean == 0) return r;
    dip = 64'(DIP_ONE);
    if (dir == DIR_X || dir == DIR_Y) begin
      h = len_sum[63:0] >> 1;
      dhs = q_mul(h, h);
      dv = 34'(p.depth_a) - 34'(p.depth_b);
      mag = (dv < 0) ? 64'(-dv) : 64'(dv);
      dvs = q_mul(mag, mag);
      if (dvs != 0) dip = q_div(dhs, q_add(dhs, dvs));
    end
    t = q_div(q_mul(q_mul(darcy_q, area), dip), mean);
    t = q_mul(t, p.mult);
    if (ovf || t > 64'(OUT_MAX)) begin
      r.trans = OUT_MAX;
      r.st = ST_SATURATED;
    end else begin
      r.trans = t[47:0];
      r.st = ST_OK;
    end
    return r;
  endfunction

  task automatic send_pair(logic [1:0] dir, pair_t p);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    s_axis_tuser  <= dir;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_transmissibility(dir, p));
    n_sent++;
  endtask

  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_darcy(logic [31:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    darcy_q = v;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_q;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return '0;
      default: return $urandom >> $urandom_range(4, 28);
    endcase
  endfunction

  function automatic pair_t rand_pair;
    pair_t p;
    p.size_x_a = rand_q(); p.size_y_a = rand_q(); p.size_z_a = rand_q();
    p.size_x_b = rand_q(); p.size_y_b = rand_q(); p.size_z_b = rand_q();
    p.perm_a = rand_q(); p.perm_b = rand_q();
    p.depth_a = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom) >>> 12);
    p.depth_b = ($urandom_range(0, 3) == 0) ? p.depth_a : $urandom;
    if ($urandom_range(0, 1)) p.depth_b = p.depth_a + 32'($signed($urandom) >>> 14);
    p.mult = ($urandom_range(0, 2) == 0) ? 32'h0001_0000 : rand_q();
    return p;
  endfunction

  function automatic pair_t unit_pair;
    pair_t p;
    p.size_x_a = 32'h0001_0000; p.size_y_a = 32'h0001_0000; p.size_z_a = 32'h0001_0000;
    p.size_x_b = 32'h0001_0000; p.size_y_b = 32'h0001_0000; p.size_z_b = 32'h0001_0000;
    p.perm_a = 32'h0001_0000; p.perm_b = 32'h0001_0000;
    p.depth_a = '0; p.depth_b = '0;
    p.mult = 32'h0001_0000;
    return p;
  endfunction

  task automatic test_directed;
    pair_t p;
    for (int d = 0; d < 4; d++) send_pair(2'(d), unit_pair());
    p = '0; send_pair(DIR_X, p);
    p = unit_pair(); p.perm_a = '0; send_pair(DIR_Y, p);
    p = unit_pair(); p.perm_b = '0; send_pair(DIR_Z, p);
    p = unit_pair(); p.size_x_a = '0; p.size_x_b = '0; send_pair(DIR_X, p);
    p = unit_pair(); p.size_z_a = 32'd1; p.size_z_b = '0; p.perm_a = '1;
    send_pair(DIR_Z, p);
    p = unit_pair(); p.depth_a = 32'sh0003_0000; send_pair(DIR_X, p);
    p = unit_pair(); p.depth_a = 32'sh7FFF_FFFF; p.depth_b = 32'sh8000_0000;
    send_pair(DIR_Y, p);
    p = unit_pair(); p.depth_a = 32'sh8000_0000; p.depth_b = 32'sh7FFF_FFFF;
    send_pair(DIR_X, p);
    p = '1; send_pair(DIR_X, p);
    p = '1; send_pair(2'd3, p);
    p = unit_pair(); p.perm_a = 32'd1; p.perm_b = 32'd1; send_pair(DIR_Z, p);
    p = unit_pair(); p.mult = '0; send_pair(DIR_Y, p);
    p = unit_pair(); p.mult = '1; send_pair(DIR_Z, p);
    p = unit_pair(); p.size_y_a = '1; p.size_z_b = '1; p.perm_a = '1; send_pair(DIR_X, p);
    p = unit_pair(); p.size_x_a = 32'h0000_0001; p.size_x_b = 32'hFFFF_FFFF;
    send_pair(DIR_X, p);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_pair(2'($urandom_range(0, 3)), rand_pair());
    drain();
  endtask

  task automatic test_backpressure;
    long_stall = 600;
    for (int i = 0; i < 300; i++) send_pair(2'($urandom_range(0, 3)), rand_pair());
    drain();
  endtask

  task automatic test_sender_pause;
    for (int i = 0; i < 50; i++) send_pair(2'($urandom_range(0, 3)), rand_pair());
    drain();
    for (int i = 0; i < 50; i++) send_pair(2'($urandom_range(0, 3)), rand_pair());
    drain();
  endtask

  // receiver: random stall bursts plus one long hold-off on request
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (long_stall > 0) begin
      stall_left = long_stall;
      long_stall = 0;
    end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    face_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result trans=%h status=%0d", $realtime,
                 m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata !== e.trans || m_axis_tuser !== e.st) begin
          $display("%0t: mismatch expected trans=%h status=%0d, actual trans=%h status=%0d",
                   $realtime, e.trans, e.st, m_axis_tdata, m_axis_tuser);
          errors++;
        end
        case (e.st)
          ST_OK: n_ok++;
          ST_ZERO_DIV: n_zero++;
          default: n_sat++;
        endcase
      end
    end
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(250);
    write_darcy(32'hFFFF_FFFF);
    test_random(150);
    write_darcy(32'h0000_0000);
    test_random(100);
    write_darcy(32'h0001_0000);
    test_backpressure();
    write_darcy(32'h0000_0001);
    test_random(100);
    write_darcy(DARCY_RESET);
    test_sender_pause();
    idle_en = 1'b0;
    test_random(300);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d cell pairs over %0d Darcy settings, with stalls on both sides.",
             n_sent, n_cfg + 1);
    $display("Results: %0d ok, %0d zero divisor, %0d saturated.", n_ok, n_zero, n_sat);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
